// ===== hdl/tcp_packet_rewrite_checksum_macros.svh =====
// Assertion macros shared by the checksum rewrite block.
`ifndef TCP_PACKET_REWRITE_CHECKSUM_MACROS_SVH
`define TCP_PACKET_REWRITE_CHECKSUM_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define TPRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tprc assertion failed");

// Next-cycle implication, checked while out of reset.
`define TPRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tprc assertion failed");

`endif

// ===== hdl/tprc_pkg.sv =====
// Package with constants, types and helpers for the checksum rewrite block.
package tprc_pkg;

    // Packet size limit and the word count that follows from it.
    localparam int MAX_PACKET_BYTES = 65536;
    localparam int MAX_WORDS        = MAX_PACKET_BYTES / 2;

    localparam int POS_W      = 15;
    localparam int HDR_WORD_W = 5;
    localparam int HDR_SUM_W  = 21;
    localparam int SEG_SUM_W  = 32;
    localparam int IP_RAW_W   = 22;

    localparam logic [POS_W-1:0]      POS_LIMIT     = 15'h7fff;
    localparam logic [HDR_WORD_W-1:0] HDR_WORDS_MIN = 5'd10;
    localparam logic [3:0]            IHL_MIN       = 4'd5;
    localparam logic [15:0]           URG_MASK      = 16'h0020;
    localparam logic [15:0]           HIGH_BYTE     = 16'hff00;
    localparam logic [15:0]           PROTO_TCP     = 16'd6;
    localparam logic [15:0]           COUNT_MAX     = 16'hffff;

    // Configuration reset values.
    localparam logic [15:0] MATCH_PORT_RESET = 16'd5001;
    localparam logic [31:0] NEW_DEST_RESET   = 32'd2154847594;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_MATCH_PORT = 1'b0,
        REG_NEW_DEST   = 1'b1
    } cfg_reg_t;

    // Header word positions that get special treatment.
    localparam logic [POS_W-1:0] POS_TOTAL_LEN = 15'd1;
    localparam logic [POS_W-1:0] POS_TTL_PROTO = 15'd4;
    localparam logic [POS_W-1:0] POS_IP_CSUM   = 15'd5;
    localparam logic [POS_W-1:0] POS_SRC_HI    = 15'd6;
    localparam logic [POS_W-1:0] POS_SRC_LO    = 15'd7;
    localparam logic [POS_W-1:0] POS_DST_HI    = 15'd8;
    localparam logic [POS_W-1:0] POS_DST_LO    = 15'd9;

    // Segment word offsets from the start of the TCP header.
    localparam logic [POS_W-1:0] SEG_SRC_PORT  = 15'd0;
    localparam logic [POS_W-1:0] SEG_FLAGS     = 15'd6;
    localparam logic [POS_W-1:0] SEG_TCP_CSUM  = 15'd8;

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Per-packet summary handed from the front part to the back part.
    typedef struct packed {
        logic [HDR_SUM_W-1:0]  header_sum;
        logic [SEG_SUM_W-1:0]  segment_sum;
        logic [15:0]           total_length;
        logic [HDR_WORD_W-1:0] header_words;
        logic                  port_ok;
        logic                  urgent_bit;
        logic [31:0]           dest_ip;
    } packet_rec_t;

    // One's-complement fold of a 32-bit sum, then complement.
    function automatic logic [15:0] fold_complement(input logic [31:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        logic [16:0] s3;
        s1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
        s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
        s3 = {1'b0, s2[15:0]} + {16'd0, s2[16]};
        return ~s3[15:0];
    endfunction

endpackage

// ===== hdl/tprc_front.sv =====
// Front part: walks the packet words, keeps running sums and classifies the packet.
module tprc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [15:0]          packet_word,
    input  logic [1:0]           byte_count,
    input  logic                 last_word,
    input  logic [15:0]          match_port,
    input  logic [31:0]          new_dest_ip,
    output logic                 push,
    output tprc_pkg::packet_rec_t rec
);

    logic [tprc_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                            overrun_reg, overrun_next;
    logic [tprc_pkg::HDR_WORD_W-1:0] hw_reg, hw_next;
    logic [15:0]                     tl_reg, tl_next;
    logic [tprc_pkg::HDR_SUM_W-1:0]  hsum_reg, hsum_next;
    logic [tprc_pkg::SEG_SUM_W-1:0]  ssum_reg, ssum_next;
    logic                            port_ok_reg, port_ok_next;
    logic                            urg_reg, urg_next;

    logic [15:0]                     w_pad;
    logic [15:0]                     w_seg;
    logic [3:0]                      ihl;
    logic [tprc_pkg::HDR_WORD_W-1:0] hw_eff;
    logic [tprc_pkg::POS_W-1:0]      seg_idx;
    logic [15:0]                     byte_off;
    logic [15:0]                     byte_off_hi;

    // Word decoding and position arithmetic.
    always_comb
    begin
        w_pad = (byte_count == 2'd1) ? (packet_word & tprc_pkg::HIGH_BYTE) : packet_word;
        ihl = (w_pad[11:8] < tprc_pkg::IHL_MIN) ? tprc_pkg::IHL_MIN : w_pad[11:8];
        hw_eff = (pos_reg == '0) ? {ihl, 1'b0} : hw_reg;
        seg_idx = pos_reg - tprc_pkg::POS_W'(hw_eff);
        byte_off = {pos_reg, 1'b0};
        byte_off_hi = byte_off + 16'd1;
    end

    // Next state for one accepted word.
    always_comb
    begin
        pos_next     = pos_reg;
        overrun_next = overrun_reg;
        hw_next      = hw_reg;
        tl_next      = tl_reg;
        hsum_next    = hsum_reg;
        ssum_next    = ssum_reg;
        port_ok_next = port_ok_reg;
        urg_next     = urg_reg;
        w_seg        = w_pad;
        if (take && !overrun_reg)
        begin
            hw_next = hw_eff;
            if (tprc_pkg::POS_W'(hw_eff) > pos_reg)
            begin
                // IP header word.
                if (pos_reg == tprc_pkg::POS_TOTAL_LEN)
                begin
                    tl_next = w_pad;
                end
                if (pos_reg == tprc_pkg::POS_TTL_PROTO)
                begin
                    hsum_next = hsum_reg + tprc_pkg::HDR_SUM_W'(w_pad & tprc_pkg::HIGH_BYTE);
                end
                else if (pos_reg != tprc_pkg::POS_IP_CSUM && pos_reg != tprc_pkg::POS_DST_HI &&
                         pos_reg != tprc_pkg::POS_DST_LO)
                begin
                    hsum_next = hsum_reg + tprc_pkg::HDR_SUM_W'(w_pad);
                end
                if (pos_reg == tprc_pkg::POS_SRC_HI || pos_reg == tprc_pkg::POS_SRC_LO)
                begin
                    ssum_next = ssum_reg + tprc_pkg::SEG_SUM_W'(w_pad);
                end
            end
            else if (byte_off < tl_reg)
            begin
                // TCP segment word inside the stated total length.
                if (byte_off_hi >= tl_reg)
                begin
                    w_seg = w_pad & tprc_pkg::HIGH_BYTE;
                end
                if (seg_idx == tprc_pkg::SEG_SRC_PORT)
                begin
                    port_ok_next = (w_seg == match_port);
                end
                if (seg_idx == tprc_pkg::SEG_FLAGS)
                begin
                    urg_next = (w_seg & tprc_pkg::URG_MASK) != '0;
                    if (port_ok_reg && urg_next)
                    begin
                        w_seg = w_seg & ~tprc_pkg::URG_MASK;
                    end
                end
                if (seg_idx != tprc_pkg::SEG_TCP_CSUM)
                begin
                    ssum_next = ssum_reg + tprc_pkg::SEG_SUM_W'(w_seg);
                end
            end
            // Position advance and overrun latch.
            if ((32'(pos_reg) + 32'd1 >= 32'(tprc_pkg::MAX_WORDS)) ||
                (pos_reg >= tprc_pkg::POS_LIMIT))
            begin
                overrun_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Packet summary leaves on the last word.
    assign push = take && last_word;
    always_comb
    begin
        rec.header_sum   = hsum_next;
        rec.segment_sum  = ssum_next;
        rec.total_length = tl_next;
        rec.header_words = hw_next;
        rec.port_ok      = port_ok_next;
        rec.urgent_bit   = urg_next;
        rec.dest_ip      = new_dest_ip;
    end

    // Per-packet state, cleared after each last word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            overrun_reg <= 1'b0;
            hw_reg      <= tprc_pkg::HDR_WORDS_MIN;
            tl_reg      <= '0;
            hsum_reg    <= '0;
            ssum_reg    <= '0;
            port_ok_reg <= 1'b0;
            urg_reg     <= 1'b0;
        end
        else if (push)
        begin
            pos_reg     <= '0;
            overrun_reg <= 1'b0;
            hw_reg      <= tprc_pkg::HDR_WORDS_MIN;
            tl_reg      <= '0;
            hsum_reg    <= '0;
            ssum_reg    <= '0;
            port_ok_reg <= 1'b0;
            urg_reg     <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            overrun_reg <= overrun_next;
            hw_reg      <= hw_next;
            tl_reg      <= tl_next;
            hsum_reg    <= hsum_next;
            ssum_reg    <= ssum_next;
            port_ok_reg <= port_ok_next;
            urg_reg     <= urg_next;
        end
    end

endmodule

// ===== hdl/tprc_fifo.sv =====
// Short queue of packet summaries between the front and back parts.
module tprc_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tprc_pkg::packet_rec_t push_rec,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output tprc_pkg::packet_rec_t pop_rec
);

    tprc_pkg::packet_rec_t             slot_reg [tprc_pkg::FIFO_DEPTH];
    logic [tprc_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [tprc_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [tprc_pkg::FIFO_CNT_W-1:0]   count_reg;

    assign full      = (count_reg == tprc_pkg::FIFO_CNT_W'(tprc_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_rec   = slot_reg[rd_ptr_reg];

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/tprc_back.sv =====
// Back part: finishes the checksums, keeps the held-packet counter and drives results.
module tprc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rec_valid,
    input  tprc_pkg::packet_rec_t rec,
    output logic                  rec_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  port_matched,
    output logic                  urgent_seen,
    output logic [15:0]           ip_header_checksum,
    output logic [15:0]           tcp_checksum,
    output logic [15:0]           held_packets
);

    logic                           a_valid_reg;
    logic [tprc_pkg::IP_RAW_W-1:0]  a_ip_raw_reg;
    logic [31:0]                    a_tcp_raw_reg;
    logic                           a_matched_reg;
    logic                           a_urgent_reg;

    logic                           out_valid_reg;
    logic                           matched_reg;
    logic                           urgent_reg;
    logic [15:0]                    ipc_reg;
    logic [15:0]                    tcpc_reg;
    logic [15:0]                    held_out_reg;
    logic [15:0]                    held_count_reg, held_count_next;

    logic                           a_load;
    logic                           b_load;
    logic [15:0]                    dest_hi;
    logic [15:0]                    dest_lo;
    logic [15:0]                    tcp_len;
    logic [15:0]                    held_inc;

    // Stage handshakes.
    assign b_load  = a_valid_reg && (!out_valid_reg || out_ready);
    assign a_load  = rec_valid && (!a_valid_reg || b_load);
    assign rec_pop = a_load;

    // Raw sums including the new destination and the pseudo-header.
    always_comb
    begin
        dest_hi = rec.dest_ip[31:16];
        dest_lo = rec.dest_ip[15:0];
        tcp_len = rec.total_length - {10'd0, rec.header_words, 1'b0};
    end

    // Counter value reported with this result, and the value kept afterwards (zero after an urgent release).
    always_comb
    begin
        held_inc = held_count_reg;
        if (a_matched_reg && held_count_reg != tprc_pkg::COUNT_MAX)
        begin
            held_inc = held_count_reg + 16'd1;
        end
        held_count_next = a_urgent_reg ? 16'd0 : held_inc;
    end

    // Stage A payload.
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_ip_raw_reg  <= tprc_pkg::IP_RAW_W'(rec.header_sum) +
                             tprc_pkg::IP_RAW_W'(tprc_pkg::PROTO_TCP) +
                             tprc_pkg::IP_RAW_W'(dest_hi) + tprc_pkg::IP_RAW_W'(dest_lo);
            a_tcp_raw_reg <= rec.segment_sum + 32'(dest_hi) + 32'(dest_lo) +
                             32'(tprc_pkg::PROTO_TCP) + 32'(tcp_len);
            a_matched_reg <= rec.port_ok;
            a_urgent_reg  <= rec.port_ok && rec.urgent_bit;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            matched_reg  <= a_matched_reg;
            urgent_reg   <= a_urgent_reg;
            ipc_reg      <= tprc_pkg::fold_complement(32'(a_ip_raw_reg));
            tcpc_reg     <= tprc_pkg::fold_complement(a_tcp_raw_reg);
            held_out_reg <= held_inc;
        end
    end

    // Valid flags and the held-packet counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_count_reg <= '0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_load)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_load)
            begin
                out_valid_reg  <= 1'b1;
                held_count_reg <= held_count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign port_matched       = matched_reg;
    assign urgent_seen        = urgent_reg;
    assign ip_header_checksum = ipc_reg;
    assign tcp_checksum       = tcpc_reg;
    assign held_packets       = held_out_reg;

endmodule

// ===== hdl/tcp_packet_rewrite_checksum.sv =====
// Top level of the IPv4/TCP checksum rewrite block.
//
// Usage: packet words enter on the in channel (in_valid/in_ready) as big-endian
// 16-bit words with byte_count and last_word. One result transaction leaves on
// the out channel (out_valid/out_ready) for each packet, after its last word.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the matched
// source port (index 0) and the substituted destination address (index 1); it
// is always ready and should only be used while no packet is in flight.
// Throughput is one word per clock while in_ready is high; the front part adds
// each word into the running sums. When the out channel is not stalled, the
// packet summary enters the queue at the edge that accepts the last word, then
// passes the stage A register with the pseudo-header sums and the output
// register with the checksum folds, where the result is shown.
// When the receiver stalls, up to four packet summaries wait in the queue plus
// two in the back pipeline; words keep flowing until the queue is full, and
// only then in_ready drops.
// Reset clears all packet state, the queue and the held-packet counter, and
// loads the configuration registers with their default values.
`include "tcp_packet_rewrite_checksum_macros.svh"

module tcp_packet_rewrite_checksum (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] packet_word,
    input  logic [1:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        port_matched,
    output logic        urgent_seen,
    output logic [15:0] ip_header_checksum,
    output logic [15:0] tcp_checksum,
    output logic [15:0] held_packets,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0]           match_port_reg;
    logic [31:0]           new_dest_reg;
    logic                  take;
    logic                  push;
    logic                  fifo_full;
    logic                  fifo_not_empty;
    logic                  fifo_pop;
    tprc_pkg::packet_rec_t front_rec;
    tprc_pkg::packet_rec_t back_rec;

    assign in_ready  = !fifo_full;
    assign take      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_port_reg <= tprc_pkg::MATCH_PORT_RESET;
            new_dest_reg   <= tprc_pkg::NEW_DEST_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tprc_pkg::REG_MATCH_PORT: match_port_reg <= cfg_data[15:0];
                tprc_pkg::REG_NEW_DEST:   new_dest_reg   <= cfg_data;
                default:                  new_dest_reg   <= new_dest_reg;
            endcase
        end
    end

    tprc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .packet_word (packet_word),
        .byte_count  (byte_count),
        .last_word   (last_word),
        .match_port  (match_port_reg),
        .new_dest_ip (new_dest_reg),
        .push        (push),
        .rec         (front_rec)
    );

    tprc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (front_rec),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .pop_rec   (back_rec)
    );

    tprc_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .rec_valid          (fifo_not_empty),
        .rec                (back_rec),
        .rec_pop            (fifo_pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .port_matched       (port_matched),
        .urgent_seen        (urgent_seen),
        .ip_header_checksum (ip_header_checksum),
        .tcp_checksum       (tcp_checksum),
        .held_packets       (held_packets)
    );

    // An urgent release is only reported for a matched packet.
    `TPRC_ASSERT_NOW(a_urgent_needs_match, out_valid && urgent_seen, port_matched)
    // A matched packet is counted unless the counter is saturated, so the reported count is never zero.
    `TPRC_ASSERT_NOW(a_matched_counted, out_valid && port_matched, held_packets != 16'd0)
    // A summary is never pushed into a full queue.
    `TPRC_ASSERT_NOW(a_no_push_when_full, fifo_full, !push)

endmodule
